/* design/dpat_pkg.sv */
// shared constants, codes and the command word for the demand-paged address translator
// no dependencies; every other design file refers to it by scoped names
package dpat_pkg;

	localparam int VA_W = 16;
	localparam int OFF_W = 8;
	localparam int PN_W = VA_W - OFF_W;
	localparam int NUM_PAGES = 1 << PN_W;
	localparam int FRAME_W = VA_W - OFF_W;
	localparam int MEM_BYTES = 1 << VA_W;
	localparam int BYTE_W = 8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = QPTR_W + 1;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_FILL = 1'b1;

	localparam logic [1:0] ST_HIT = 2'd0;
	localparam logic [1:0] ST_FAULT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_ERROR = 2'd3;

	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_HIT = 3'd1;
	localparam logic [2:0] CMD_FAULT = 3'd2;
	localparam logic [2:0] CMD_DONE = 3'd3;
	localparam logic [2:0] CMD_ERROR = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [VA_W-1:0] rd_addr;
		logic [VA_W-1:0] wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic [PN_W-1:0] page;
	} cmd_t;

endpackage

/* design/demand_paged_address_translator_core.sv */
// a word passes the front stage register, a queue slot and the result register
// throughput: one word per cycle; busy rises only if the command queue would overflow
// a fill byte before the last one gives no result; every other word gives exactly one
// reset clears page table valid bits, free frame counter, fill state and queue pointers
// physical memory needs no clearing pass and is undefined until a fill writes it
// the receiver cannot stall: results are never held back
module demand_paged_address_translator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic op,
	input  logic [dpat_pkg::VA_W-1:0] virtual_address,
	input  logic [dpat_pkg::BYTE_W-1:0] fill_byte,
	output logic strobe,
	output logic [1:0] status,
	output logic [dpat_pkg::VA_W-1:0] physical_address,
	output logic signed [dpat_pkg::BYTE_W-1:0] value,
	output logic [dpat_pkg::PN_W-1:0] fault_page
);

	logic push;
	logic pop;
	dpat_pkg::cmd_t cmd;
	dpat_pkg::cmd_t head;
	logic [dpat_pkg::QLVL_W-1:0] q_level;

	dpat_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.virtual_address(virtual_address),
		.fill_byte(fill_byte),
		.q_level(q_level),
		.push(push),
		.cmd(cmd)
	);

	dpat_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(cmd),
		.pop(pop),
		.head(head),
		.level(q_level)
	);

	dpat_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop(pop),
		.head(head),
		.strobe(strobe),
		.status(status),
		.physical_address(physical_address),
		.value(value),
		.fault_page(fault_page)
	);

endmodule

/* design/dpat_front.sv */
// front end: accepts words, looks up the page table and keeps the fill bookkeeping
// depends on dpat_pkg; emits one command word per accepted word into the queue
module dpat_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic op,
	input  logic [dpat_pkg::VA_W-1:0] virtual_address,
	input  logic [dpat_pkg::BYTE_W-1:0] fill_byte,
	input  logic [dpat_pkg::QLVL_W-1:0] q_level,
	output logic push,
	output dpat_pkg::cmd_t cmd
);

	localparam int LW = dpat_pkg::QLVL_W;
	localparam int OW = dpat_pkg::OFF_W;
	localparam int FW = dpat_pkg::FRAME_W;
	localparam int PW = dpat_pkg::PN_W;
	localparam int VW = dpat_pkg::VA_W;

	logic accept;
	logic v_s1;
	logic op_s1;
	logic [VW-1:0] va_s1;
	logic [dpat_pkg::BYTE_W-1:0] fb_s1;
	logic [FW-1:0] frame_rd_s1;
	logic fwd_s1;
	logic [FW-1:0] fwd_frame_s1;

	logic [dpat_pkg::NUM_PAGES-1:0] valid_q;
	logic [FW-1:0] frame_mem [dpat_pkg::NUM_PAGES];
	logic fill_pending_q;
	logic [VW-1:0] pending_q;
	logic [OW-1:0] fill_count_q;
	logic [FW:0] next_free_q;

	logic [PW-1:0] page_s1;
	logic [PW-1:0] pend_page;
	logic [FW-1:0] frame_hit;
	logic start_fill;
	logic fill_step;
	logic fill_last;

	assign busy = (q_level + LW'(v_s1)) >= LW'(dpat_pkg::QDEPTH);
	assign accept = start && !busy;
	assign push = v_s1;

	assign page_s1 = va_s1[VW-1:OW];
	assign pend_page = pending_q[VW-1:OW];
	// the table read misses a write that lands on the same edge
	assign frame_hit = fwd_s1 ? fwd_frame_s1 : frame_rd_s1;

	always_comb begin
		cmd = '0;
		cmd.kind = dpat_pkg::CMD_ERROR;
		start_fill = 1'b0;
		fill_step = 1'b0;
		fill_last = 1'b0;
		if (op_s1 == dpat_pkg::OP_READ) begin
			if (fill_pending_q) begin
				cmd.kind = dpat_pkg::CMD_ERROR;
			end else if (valid_q[page_s1]) begin
				cmd.kind = dpat_pkg::CMD_HIT;
				cmd.rd_addr = {frame_hit, va_s1[OW-1:0]};
			end else if (next_free_q[FW]) begin
				cmd.kind = dpat_pkg::CMD_ERROR;
			end else begin
				start_fill = 1'b1;
				cmd.kind = dpat_pkg::CMD_FAULT;
				cmd.page = page_s1;
			end
		end else if (fill_pending_q) begin
			cmd.wr_addr = {next_free_q[FW-1:0], fill_count_q};
			cmd.wr_data = fb_s1;
			if (fill_count_q == '1) begin
				fill_last = 1'b1;
				cmd.kind = dpat_pkg::CMD_DONE;
				cmd.rd_addr = {next_free_q[FW-1:0], pending_q[OW-1:0]};
			end else begin
				fill_step = 1'b1;
				cmd.kind = dpat_pkg::CMD_WRITE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			valid_q <= '0;
			fill_pending_q <= 1'b0;
			pending_q <= '0;
			fill_count_q <= '0;
			next_free_q <= '0;
		end else begin
			v_s1 <= accept;
			if (v_s1 && start_fill) begin
				fill_pending_q <= 1'b1;
				pending_q <= va_s1;
				fill_count_q <= '0;
			end
			if (v_s1 && fill_step) begin
				fill_count_q <= fill_count_q + 1'b1;
			end
			if (v_s1 && fill_last) begin
				valid_q[pend_page] <= 1'b1;
				next_free_q <= next_free_q + 1'b1;
				fill_pending_q <= 1'b0;
				fill_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && fill_last) begin
			frame_mem[pend_page] <= next_free_q[FW-1:0];
		end
		if (accept) begin
			op_s1 <= op;
			va_s1 <= virtual_address;
			fb_s1 <= fill_byte;
			frame_rd_s1 <= frame_mem[virtual_address[VW-1:OW]];
			fwd_s1 <= v_s1 && fill_last && (pend_page == virtual_address[VW-1:OW]);
			fwd_frame_s1 <= next_free_q[FW-1:0];
		end
	end

endmodule

/* design/dpat_queue.sv */
// short command queue between front end and back end
// depends on dpat_pkg for the command word and depth
module dpat_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dpat_pkg::cmd_t din,
	output logic pop,
	output dpat_pkg::cmd_t head,
	output logic [dpat_pkg::QLVL_W-1:0] level
);

	localparam int PW = dpat_pkg::QPTR_W;

	dpat_pkg::cmd_t slot_q [dpat_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [dpat_pkg::QLVL_W-1:0] level_q;

	// back end never stalls, so the head leaves whenever there is one
	assign pop = level_q != '0;
	assign head = slot_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* design/dpat_back.sv */
// back end: physical memory access and result register
// depends on dpat_pkg; takes one command word per cycle from the queue
module dpat_back (
	input  logic clk,
	input  logic arst_n,
	input  logic pop,
	input  dpat_pkg::cmd_t head,
	output logic strobe,
	output logic [1:0] status,
	output logic [dpat_pkg::VA_W-1:0] physical_address,
	output logic signed [dpat_pkg::BYTE_W-1:0] value,
	output logic [dpat_pkg::PN_W-1:0] fault_page
);

	localparam int BW = dpat_pkg::BYTE_W;

	logic [BW-1:0] mem [dpat_pkg::MEM_BYTES];
	logic we;
	logic is_read;
	logic [1:0] st;

	logic strobe_q;
	logic [1:0] status_q;
	logic [dpat_pkg::VA_W-1:0] pa_q;
	logic [dpat_pkg::PN_W-1:0] fpage_q;
	logic is_read_q;
	logic fwd_q;
	logic [BW-1:0] wdata_q;
	logic [BW-1:0] rdata_q;

	always_comb begin
		we = 1'b0;
		is_read = 1'b0;
		unique case (head.kind)
			dpat_pkg::CMD_WRITE: begin
				we = 1'b1;
				st = dpat_pkg::ST_ERROR;
			end
			dpat_pkg::CMD_HIT: begin
				is_read = 1'b1;
				st = dpat_pkg::ST_HIT;
			end
			dpat_pkg::CMD_FAULT: begin
				st = dpat_pkg::ST_FAULT;
			end
			dpat_pkg::CMD_DONE: begin
				we = 1'b1;
				is_read = 1'b1;
				st = dpat_pkg::ST_DONE;
			end
			default: begin
				st = dpat_pkg::ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= pop && (head.kind != dpat_pkg::CMD_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (we) begin
				mem[head.wr_addr] <= head.wr_data;
			end
			rdata_q <= mem[head.rd_addr];
			status_q <= st;
			pa_q <= is_read ? head.rd_addr : '0;
			fpage_q <= (head.kind == dpat_pkg::CMD_FAULT) ? head.page : '0;
			is_read_q <= is_read;
			// last fill byte may be the very byte being read back
			fwd_q <= we && (head.rd_addr == head.wr_addr);
			wdata_q <= head.wr_data;
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign physical_address = pa_q;
	assign fault_page = fpage_q;
	assign value = is_read_q ? signed'(fwd_q ? wdata_q : rdata_q) : '0;

endmodule

/* design/dpat_checker.sv */
// port-level checks for the demand-paged address translator
// depends on dpat_pkg; bound to the top level at the end of this file
module dpat_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic op,
	input logic strobe,
	input logic [1:0] status,
	input logic [dpat_pkg::VA_W-1:0] physical_address,
	input logic signed [dpat_pkg::BYTE_W-1:0] value,
	input logic [dpat_pkg::PN_W-1:0] fault_page
);

	// a translate word always answers with a result strobe
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == dpat_pkg::OP_READ) |-> ##3 strobe)
		else $error("translate word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 3))
		else $error("result with no word accepted");

	a_fault_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == dpat_pkg::ST_FAULT) |-> $past(op == dpat_pkg::OP_READ, 3))
		else $error("fault raised by a fill word");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == dpat_pkg::ST_ERROR) |->
			(physical_address == '0) && (value == '0) && (fault_page == '0))
		else $error("error result carries data");

endmodule

bind demand_paged_address_translator_core dpat_checker u_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// self-checking bench for demand_paged_address_translator_core: directed table, then random
// accesses and page fills; results are checked against table rows or a page table and memory image kept here
// depends on dpat_pkg and the core only
module tb_top;

	localparam int VA_W = dpat_pkg::VA_W;
	localparam int OFF_W = dpat_pkg::OFF_W;
	localparam int PN_W = dpat_pkg::PN_W;
	localparam int FRAME_W = dpat_pkg::FRAME_W;
	localparam int BYTE_W = dpat_pkg::BYTE_W;
	localparam int NUM_PAGES = dpat_pkg::NUM_PAGES;
	localparam int MEM_BYTES = dpat_pkg::MEM_BYTES;
	localparam logic OP_READ = dpat_pkg::OP_READ;
	localparam logic OP_FILL = dpat_pkg::OP_FILL;
	localparam logic [1:0] ST_HIT = dpat_pkg::ST_HIT;
	localparam logic [1:0] ST_FAULT = dpat_pkg::ST_FAULT;
	localparam logic [1:0] ST_DONE = dpat_pkg::ST_DONE;
	localparam logic [1:0] ST_ERROR = dpat_pkg::ST_ERROR;

	localparam int FRAME_COUNT = MEM_BYTES / (1 << OFF_W);
	localparam int RAND_WORDS = 420;

	typedef struct packed {
		logic [1:0] st;
		logic [VA_W-1:0] pa;
		logic [BYTE_W-1:0] val;
		logic [PN_W-1:0] fpage;
	} xlat_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_t;

	typedef struct packed {
		logic opc;
		logic [VA_W-1:0] va;
		logic [BYTE_W-1:0] fb;
		logic [BYTE_W-1:0] fb_step;
		logic [8:0] reps;
		chk_t chk;
		xlat_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = OP_READ;
	logic [VA_W-1:0] virtual_address = '0;
	logic [BYTE_W-1:0] fill_byte = '0;
	logic busy;
	logic strobe;
	logic [1:0] status;
	logic [VA_W-1:0] physical_address;
	logic signed [BYTE_W-1:0] value;
	logic [PN_W-1:0] fault_page;

	demand_paged_address_translator_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#500_000;
		$display("status: fail");
		$finish;
	end

	// translation state mirrored from the core
	bit pt_ok [NUM_PAGES];
	logic [FRAME_W-1:0] pt_frame [NUM_PAGES];
	logic [FRAME_W:0] free_frame = '0;
	logic [BYTE_W-1:0] mem_img [MEM_BYTES];
	bit fill_busy = 1'b0;
	logic [VA_W-1:0] pend_va = '0;
	logic [OFF_W-1:0] fill_idx = '0;
	logic [PN_W-1:0] mapped_pages [$];

	xlat_t pending_results [$];
	int mismatches = 0;
	bit gaps_on = 1'b1;

	stim_row_t dir_rows [18] = '{
		'{OP_READ, 16'h0000, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_FAULT, 16'h0000, 8'h00, 8'h00}},
		'{OP_READ, 16'h1234, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_ERROR, 16'h0000, 8'h00, 8'h00}},
		'{OP_FILL, 16'h0000, 8'h80, 8'h01, 9'd255, CHK_NONE, '0},
		'{OP_FILL, 16'hFFFF, 8'h7F, 8'h00, 9'd1, CHK_TYPED, '{ST_DONE, 16'h0000, 8'h80, 8'h00}},
		'{OP_READ, 16'h00FF, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_HIT, 16'h00FF, 8'h7F, 8'h00}},
		'{OP_READ, 16'h0080, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_HIT, 16'h0080, 8'h00, 8'h00}},
		'{OP_FILL, 16'h0000, 8'hFF, 8'h00, 9'd1, CHK_TYPED, '{ST_ERROR, 16'h0000, 8'h00, 8'h00}},
		'{OP_READ, 16'hFFFF, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_FAULT, 16'h0000, 8'h00, 8'hFF}},
		'{OP_FILL, 16'h5A5A, 8'h00, 8'h35, 9'd256, CHK_MODEL, '0},
		'{OP_READ, 16'hFF00, 8'h00, 8'h00, 9'd1, CHK_MODEL, '0},
		'{OP_READ, 16'h8001, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_FAULT, 16'h0000, 8'h00, 8'h80}},
		'{OP_READ, 16'h8001, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_ERROR, 16'h0000, 8'h00, 8'h00}},
		'{OP_FILL, 16'hA5A5, 8'hAA, 8'h00, 9'd255, CHK_NONE, '0},
		'{OP_READ, 16'h0000, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_ERROR, 16'h0000, 8'h00, 8'h00}},
		'{OP_FILL, 16'h0000, 8'h55, 8'h00, 9'd1, CHK_TYPED, '{ST_DONE, 16'h0201, 8'hAA, 8'h00}},
		'{OP_READ, 16'h80FE, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_HIT, 16'h02FE, 8'hAA, 8'h00}},
		'{OP_READ, 16'h80FF, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_HIT, 16'h02FF, 8'h55, 8'h00}},
		'{OP_READ, 16'h7FFF, 8'h00, 8'h00, 9'd1, CHK_TYPED, '{ST_FAULT, 16'h0000, 8'h00, 8'h7F}}
	};

	function automatic bit translate_model(input logic opc, input logic [VA_W-1:0] va,
			input logic [BYTE_W-1:0] fb, output xlat_t r);
		logic [PN_W-1:0] pg;
		logic [VA_W-1:0] pa;
		logic [FRAME_W-1:0] frame;
		r = '0;
		pg = va[VA_W-1:OFF_W];
		if (opc == OP_READ) begin
			if (fill_busy || free_frame >= FRAME_COUNT && !pt_ok[pg]) begin
				r.st = ST_ERROR;
				return 1'b1;
			end
			if (pt_ok[pg]) begin
				pa = {pt_frame[pg], va[OFF_W-1:0]};
				r = '{ST_HIT, pa, mem_img[pa], 8'h00};
				return 1'b1;
			end
			fill_busy = 1'b1;
			pend_va = va;
			fill_idx = '0;
			r.st = ST_FAULT;
			r.fpage = pg;
			return 1'b1;
		end
		if (!fill_busy) begin
			r.st = ST_ERROR;
			return 1'b1;
		end
		frame = free_frame[FRAME_W-1:0];
		mem_img[{frame, fill_idx}] = fb;
		if (fill_idx != {OFF_W{1'b1}}) begin
			fill_idx++;
			return 1'b0;
		end
		// last byte of the page: map it and finish the faulted read
		pg = pend_va[VA_W-1:OFF_W];
		pt_ok[pg] = 1'b1;
		pt_frame[pg] = frame;
		mapped_pages.push_back(pg);
		free_frame++;
		fill_busy = 1'b0;
		fill_idx = '0;
		pa = {frame, pend_va[OFF_W-1:0]};
		r = '{ST_DONE, pa, mem_img[pa], 8'h00};
		return 1'b1;
	endfunction

	task automatic issue_word(input logic opc, input logic [VA_W-1:0] va,
			input logic [BYTE_W-1:0] fb, input chk_t chk, input xlat_t want);
		xlat_t got;
		bit has;
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		op <= opc;
		virtual_address <= va;
		fill_byte <= fb;
		@(posedge clk);
		while (busy) @(posedge clk);
		has = translate_model(opc, va, fb, got);
		if (chk == CHK_TYPED)
			pending_results.push_back(want);
		else if (chk == CHK_MODEL && has)
			pending_results.push_back(got);
	endtask

	task automatic settle_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VA_W-1:0] mapped_addr();
		logic [PN_W-1:0] pg;
		pg = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
		return {pg, OFF_W'($urandom)};
	endfunction

	always @(posedge clk) begin : result_check
		xlat_t want_w;
		xlat_t got_w;
		if (strobe) begin
			got_w = {status, physical_address, value, fault_page};
			if (pending_results.size() == 0) begin
				$display("%0t unexpected word: status=%0d pa=%h value=%h fault_page=%h",
					$time, status, physical_address, value, fault_page);
				mismatches++;
			end else begin
				want_w = pending_results.pop_front();
				if (got_w !== want_w) begin
					$display("%0t mismatch: expected status=%0d pa=%h value=%h fault_page=%h",
						$time, want_w.st, want_w.pa, want_w.val, want_w.fpage);
					$display("%0t           actual   status=%0d pa=%h value=%h fault_page=%h",
						$time, status, physical_address, value, fault_page);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int words;
		int pick;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			for (int k = 0; k < dir_rows[r].reps; k++)
				issue_word(dir_rows[r].opc, dir_rows[r].va,
					dir_rows[r].fb + BYTE_W'(k * dir_rows[r].fb_step),
					dir_rows[r].chk, dir_rows[r].want);

		// random accesses: hits on mapped pages, faults followed by full fills,
		// and stray words that break the fill protocol; the first third runs with no gaps
		words = 0;
		while (words < RAND_WORDS) begin
			gaps_on = (words >= RAND_WORDS / 3);
			if (words == RAND_WORDS / 2)
				settle_results();
			pick = $urandom_range(0, 99);
			if (fill_busy) begin
				if (pick < 3)
					issue_word(OP_READ, VA_W'($urandom), BYTE_W'($urandom), CHK_MODEL, '0);
				else
					issue_word(OP_FILL, VA_W'($urandom), BYTE_W'($urandom), CHK_MODEL, '0);
			end else if (pick < 6) begin
				issue_word(OP_FILL, VA_W'($urandom), BYTE_W'($urandom), CHK_MODEL, '0);
			end else if (pick < 85 && mapped_pages.size() != 0) begin
				issue_word(OP_READ, mapped_addr(), BYTE_W'($urandom), CHK_MODEL, '0);
			end else begin
				issue_word(OP_READ, VA_W'($urandom), BYTE_W'($urandom), CHK_MODEL, '0);
			end
			words++;
		end

		settle_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
